@@ design/simon_block_encrypt_core_macros.svh @@
// Assertion macros shared by the Simon block encryption core.
// No dependencies; included by the files that carry assertions.
`ifndef SIMON_BLOCK_ENCRYPT_CORE_MACROS_SVH
`define SIMON_BLOCK_ENCRYPT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/sbe_pkg.sv @@
// Package for the Simon 128/128 encryption core: word type, constants,
// register codes and the round and key schedule functions. No dependencies.
package sbe_pkg;

    localparam int WORD_W         = 64;
    localparam int DEFAULT_ROUNDS = 68;
    localparam int CFG_IDX_W      = 8;
    localparam int Z2_PERIOD      = 62;
    localparam int Z2_IDX_W       = 6;

    typedef logic [WORD_W-1:0] word_t;

    // z2 sequence: bit j of the sequence is bit (61 - j) of this constant.
    localparam logic [Z2_PERIOD-1:0] Z2_SEQ      = 62'h2BDC0D262847E5B3;
    localparam word_t                SCHED_CONST = 64'h3;

    // Configuration register codes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ZERO = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ONE  = 8'd1;

    // One Feistel round: new x from the current x, y and round key.
    function automatic word_t round_x(input word_t x, input word_t y, input word_t k);
        word_t r1;
        word_t r2;
        word_t r8;
        r1 = {x[WORD_W-2:0], x[WORD_W-1]};
        r2 = {x[WORD_W-3:0], x[WORD_W-1:WORD_W-2]};
        r8 = {x[WORD_W-9:0], x[WORD_W-1:WORD_W-8]};
        return y ^ (r1 & r8) ^ r2 ^ k;
    endfunction

    // Two-word key schedule step: k[i+2] from k[i], k[i+1] and a z2 bit.
    function automatic word_t key_step(input word_t k_old, input word_t k_last,
                                       input logic zbit);
        word_t t;
        t = {k_last[2:0], k_last[WORD_W-1:3]};
        t = t ^ {t[0], t[WORD_W-1:1]};
        return ~k_old ^ t ^ {{(WORD_W-1){1'b0}}, zbit} ^ SCHED_CONST;
    endfunction

endpackage

@@ design/simon_block_encrypt_core.sv @@
// Simon 128/128 encryption core: one round per pipeline stage plus the key
// schedule sequencer. Depends on sbe_pkg and simon_block_encrypt_core_macros.svh.

// The core accepts one 128-bit block per cycle while s_tready is high. An
// accepted beat passes through the ROUNDS register stages (one Feistel
// round each) in order, and the last stage offers its result beat.
// A result beat that is offered but not taken (m_tvalid high, m_tready
// low) freezes the whole pipeline. After reset and after every key register
// write the round keys are rebuilt by a schedule sequencer that produces
// one key per cycle, so s_tready stays low until all ROUNDS keys are in place
// (68 by default) before the first block is taken. Key writes are meant for
// an idle pipeline.
`include "simon_block_encrypt_core_macros.svh"

module simon_block_encrypt_core
    import sbe_pkg::*;
#(
    parameter int ROUNDS = DEFAULT_ROUNDS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input block beats.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*WORD_W-1:0]  s_tdata,   // plain_right [63:0], plain_left [127:64]
    // Result beats.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*WORD_W-1:0]  m_tdata,   // cipher_right [63:0], cipher_left [127:64]
    // Key register writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    localparam int              CW       = $clog2(ROUNDS + 1);
    localparam logic [CW-1:0]   CNT_DONE = CW'(ROUNDS);
    localparam logic [CW-1:0]   CNT_ONE  = CW'(1);
    localparam logic [CW-1:0]   CNT_TWO  = CW'(2);
    localparam logic [Z2_IDX_W-1:0] Z2_LAST = Z2_IDX_W'(Z2_PERIOD - 1);

    // Key words and schedule state.
    word_t                 key0_reg, key1_reg;
    word_t                 sched_a_reg, sched_b_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [Z2_IDX_W-1:0]   zidx_reg, zidx_next;
    word_t                 key_reg [ROUNDS];
    word_t                 key_new;
    logic                  busy;
    logic                  key_write;
    logic                  zbit;

    // Pipeline state.
    logic [ROUNDS-1:0]     v_reg, v_next;
    word_t                 x_reg [ROUNDS];
    word_t                 y_reg [ROUNDS];
    logic                  pipe_en;
    logic                  s_fire;

    // Configuration channel: always ready; only the two key indexes act.
    assign cfg_ready = 1'b1;

    always_comb begin
        key_write = 1'b0;
        unique case (cfg_index)
            REG_KEY_WORD_ZERO: key_write = cfg_valid;
            REG_KEY_WORD_ONE:  key_write = cfg_valid;
            default:           key_write = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= word_t'(1);
            key1_reg <= word_t'(1);
        end else if (cfg_valid && cfg_index == REG_KEY_WORD_ZERO) begin
            key0_reg <= cfg_data;
        end else if (cfg_valid && cfg_index == REG_KEY_WORD_ONE) begin
            key1_reg <= cfg_data;
        end
    end

    // Schedule sequencer: step counter and z2 index.
    assign busy = (cnt_reg != CNT_DONE);
    assign zbit = Z2_SEQ[Z2_LAST - zidx_reg];

    always_comb begin
        cnt_next  = cnt_reg;
        zidx_next = zidx_reg;
        if (key_write) begin
            cnt_next  = '0;
            zidx_next = '0;
        end else if (busy) begin
            cnt_next = cnt_reg + CNT_ONE;
            if (cnt_reg >= CNT_TWO) begin
                zidx_next = (zidx_reg == Z2_LAST) ? '0 : zidx_reg + Z2_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            zidx_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            zidx_reg <= zidx_next;
        end
    end

    // The key of this step: the two key words first, then the schedule.
    always_comb begin
        if (cnt_reg == '0) begin
            key_new = key0_reg;
        end else if (cnt_reg == CNT_ONE) begin
            key_new = key1_reg;
        end else begin
            key_new = key_step(sched_a_reg, sched_b_reg, zbit);
        end
    end

    // Keys shift in from the top so that stage r ends up holding key r.
    always_ff @(posedge aclk) begin
        if (busy) begin
            sched_a_reg <= sched_b_reg;
            sched_b_reg <= key_new;
            key_reg[ROUNDS-1] <= key_new;
            for (int i = 0; i < ROUNDS - 1; i++) begin
                key_reg[i] <= key_reg[i+1];
            end
        end
    end

    // Pipeline enable: advance unless the output beat is held.
    assign pipe_en  = m_tready || !m_tvalid;
    assign s_tready = pipe_en && !busy;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        v_next[0] = s_fire;
        for (int r = 1; r < ROUNDS; r++) begin
            v_next[r] = v_reg[r-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (pipe_en) begin
            v_reg <= v_next;
        end
    end

    // One round per stage.
    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        word_t x_in;
        word_t y_in;
        if (r == 0) begin : g_first
            assign y_in = s_tdata[WORD_W-1:0];
            assign x_in = s_tdata[2*WORD_W-1:WORD_W];
        end else begin : g_rest
            assign y_in = y_reg[r-1];
            assign x_in = x_reg[r-1];
        end
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                x_reg[r] <= round_x(x_in, y_in, key_reg[r]);
                y_reg[r] <= x_in;
            end
        end
    end

    // Result beat from the last stage.
    assign m_tvalid = v_reg[ROUNDS-1];
    assign m_tdata  = {x_reg[ROUNDS-1], y_reg[ROUNDS-1]};

    // A key write restarts the schedule sequencer.
    `SBE_ASSERT_NEXT(a_key_write_restarts, aclk, aresetn, key_write, cnt_reg == '0)
    // No block is taken while round keys are being rebuilt.
    `SBE_ASSERT_SAME(a_no_input_while_busy, aclk, aresetn, busy, !s_tready)
    // An accepted beat lands in the first stage.
    `SBE_ASSERT_NEXT(a_accept_enters_stage0, aclk, aresetn, s_fire, v_reg[0])
    // A stall freezes every stage's valid bit.
    `SBE_ASSERT_NEXT(a_stall_freezes_pipe, aclk, aresetn, !pipe_en, $stable(v_reg))

endmodule
